// File: rtl/relative_page_extent_map_assert.svh
// ----------------------------------------------------------------------------
// Relative page extent map assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef RELATIVE_PAGE_EXTENT_MAP_ASSERT_SVH
`define RELATIVE_PAGE_EXTENT_MAP_ASSERT_SVH

// Same-cycle implication, inactive while reset is applied.
`define RPEM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive while reset is applied.
`define RPEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset itself.
`define RPEM_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rpem_pkg.sv
// ----------------------------------------------------------------------------
// Relative page extent map package
// Widths, command and status codes, and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpem_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int PAGE_W      = 64;
  localparam int CNT_W       = 32;
  localparam int ENTRY_W     = 2 * PAGE_W;
  localparam int IN_TDATA_W  = 168;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    CMD_ASSIGN  = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_REL2STO = 2'd2,
    CMD_STO2REL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UPDATE,
    S_SEARCH,
    S_FETCH,
    S_ADD,
    S_DONE
  } state_t;

endpackage

// File: rtl/relative_page_extent_map.sv
// ----------------------------------------------------------------------------
// Relative page extent map
// Extent table with page assignment, extent recording and floor lookups.
// ----------------------------------------------------------------------------
// The block handles one request at a time. Assign and add-mapping requests
// pass through the execute, update and done states to a valid result: the
// checks run against the origin registers and a cached copy of the newest
// table entry, and an append is a single write into the extent memory. The
// two lookups are binary floor searches over the extent memory, one read per
// search step, each step halving the range still to search; the single read
// port of that memory sets the pace. A new request is taken while the
// previous result still waits on the output register. The memory needs no
// clearing after reset: entries at or above the entry count are never read.
`timescale 1ns / 1ps

module relative_page_extent_map import rpem_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // storage_page [63:0], relative_page [127:64], page_count [159:128],
  // first_in_step [160], zero fill [167:161]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd [1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // page_out [63:0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status [1:0]
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Extent memory: storage start in the upper half, relative start below.
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [ENTRY_W-1:0] mem_wd;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  state_t state_r, state_nxt;

  cmd_t              cmd_r, cmd_nxt;
  logic [PAGE_W-1:0] sto_r, sto_nxt;
  logic [PAGE_W-1:0] rel_r, rel_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              first_r, first_nxt;

  logic [CW-1:0]     count_r, count_nxt;
  logic [PAGE_W-1:0] so_r, so_nxt;
  logic [PAGE_W-1:0] ro_r, ro_nxt;
  logic [PAGE_W-1:0] highest_r, highest_nxt;
  logic [PAGE_W-1:0] last_rel_r, last_rel_nxt;
  logic [PAGE_W-1:0] last_sto_r, last_sto_nxt;

  logic [PAGE_W-1:0] sd_r, sd_nxt;
  logic              sto_lt_r, sto_lt_nxt;
  logic [PAGE_W-1:0] rd_r, rd_nxt;
  logic              rel_lt_r, rel_lt_nxt;
  logic [PAGE_W-1:0] end_r, end_nxt;
  logic              end_ovf_r, end_ovf_nxt;
  logic              rel_le_last_r, rel_le_last_nxt;
  logic              sto_le_last_r, sto_le_last_nxt;

  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [PAGE_W-1:0] diff_r, diff_nxt;
  logic [PAGE_W-1:0] base_r, base_nxt;

  logic [PAGE_W-1:0] res_page_r, res_page_nxt;
  status_t           res_status_r, res_status_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;
  status_t           out_status_r, out_status_nxt;

  always_comb begin
    logic [PAGE_W:0]   sum65;
    logic [PAGE_W:0]   sub65;
    logic [CNT_W-1:0]  cnt_m1;
    logic [PAGE_W-1:0] new_rel;
    logic [PAGE_W-1:0] key;
    logic [PAGE_W-1:0] ent_key;
    logic [PAGE_W-1:0] ent_other;
    logic              key_le;
    logic [CW-1:0]     lo_n;
    logic [CW-1:0]     hi_n;
    logic [CW-1:0]     mid_n;

    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    sto_nxt         = sto_r;
    rel_nxt         = rel_r;
    cnt_nxt         = cnt_r;
    first_nxt       = first_r;
    count_nxt       = count_r;
    so_nxt          = so_r;
    ro_nxt          = ro_r;
    highest_nxt     = highest_r;
    last_rel_nxt    = last_rel_r;
    last_sto_nxt    = last_sto_r;
    sd_nxt          = sd_r;
    sto_lt_nxt      = sto_lt_r;
    rd_nxt          = rd_r;
    rel_lt_nxt      = rel_lt_r;
    end_nxt         = end_r;
    end_ovf_nxt     = end_ovf_r;
    rel_le_last_nxt = rel_le_last_r;
    sto_le_last_nxt = sto_le_last_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    diff_nxt        = diff_r;
    base_nxt        = base_r;
    res_page_nxt    = res_page_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r;
    out_page_nxt    = out_page_r;
    out_status_nxt  = out_status_r;

    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = count_r[AW-1:0];
    mem_wd    = {sto_r, rel_r};
    rd_en     = 1'b0;
    rd_addr   = mid_r[AW-1:0];

    sum65     = '0;
    sub65     = '0;
    cnt_m1    = cnt_r - CNT_W'(1);
    new_rel   = highest_r + PAGE_W'(1);
    key       = (cmd_r == CMD_REL2STO) ? rel_r : sto_r;
    ent_key   = (cmd_r == CMD_REL2STO) ? rd_data_r[PAGE_W-1:0]
                                       : rd_data_r[ENTRY_W-1:PAGE_W];
    ent_other = (cmd_r == CMD_REL2STO) ? rd_data_r[ENTRY_W-1:PAGE_W]
                                       : rd_data_r[PAGE_W-1:0];
    key_le    = (ent_key <= key);
    lo_n      = key_le ? (mid_r + CW'(1)) : lo_r;
    hi_n      = key_le ? hi_r : mid_r;
    mid_n     = lo_n + ((hi_n - lo_n) >> 1);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = cmd_t'(in_tuser[1:0]);
          sto_nxt   = in_tdata[63:0];
          rel_nxt   = in_tdata[127:64];
          cnt_nxt   = in_tdata[159:128];
          first_nxt = in_tdata[160];
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        sub65           = {1'b0, sto_r} - {1'b0, so_r};
        sd_nxt          = sub65[PAGE_W-1:0];
        sto_lt_nxt      = sub65[PAGE_W];
        rd_nxt          = rel_r - ro_r;
        rel_lt_nxt      = (rel_r < highest_r);
        sum65           = {1'b0, rel_r} + {{(PAGE_W + 1 - CNT_W){1'b0}}, cnt_m1};
        end_nxt         = sum65[PAGE_W-1:0];
        end_ovf_nxt     = sum65[PAGE_W];
        rel_le_last_nxt = (rel_r <= last_rel_r);
        sto_le_last_nxt = (sto_r <= last_sto_r);
        res_page_nxt    = '0;
        res_status_nxt  = ST_OK;
        if (cmd_r == CMD_REL2STO || cmd_r == CMD_STO2REL) begin
          if (count_r == '0) begin
            res_status_nxt = ST_MISS;
            state_nxt      = S_DONE;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = count_r;
            mid_nxt   = count_r >> 1;
            rd_en     = 1'b1;
            rd_addr   = mid_nxt[AW-1:0];
            state_nxt = S_SEARCH;
          end
        end else begin
          state_nxt = S_UPDATE;
        end
      end

      S_UPDATE: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_ASSIGN: begin
            if (sto_lt_r) begin
              res_status_nxt = ST_ORDER;
            end else if (first_r && sd_r != '0) begin
              // First assign of a step at a new storage page opens an extent.
              if (&highest_r) begin
                res_status_nxt = ST_ORDER;
              end else if (count_r >= DEPTH_C) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_wd       = {sto_r, new_rel};
                count_nxt    = count_r + CW'(1);
                ro_nxt       = new_rel;
                so_nxt       = sto_r;
                highest_nxt  = new_rel;
                last_rel_nxt = new_rel;
                last_sto_nxt = sto_r;
                res_page_nxt = new_rel;
              end
            end else begin
              sum65 = {1'b0, ro_r} + {1'b0, sd_r};
              if (sum65[PAGE_W]) begin
                res_status_nxt = ST_ORDER;
              end else begin
                res_page_nxt = sum65[PAGE_W-1:0];
                if (sum65[PAGE_W-1:0] > highest_r) begin
                  highest_nxt = sum65[PAGE_W-1:0];
                end
              end
            end
          end
          CMD_ADD: begin
            if (cnt_r == '0 || sto_lt_r || rel_lt_r || end_ovf_r) begin
              res_status_nxt = ST_ORDER;
            end else if (count_r != '0 && sd_r == rd_r) begin
              // Continues the current extent: no new table entry.
              highest_nxt = end_r;
            end else if (count_r != '0 && (rel_le_last_r || sto_le_last_r)) begin
              res_status_nxt = ST_ORDER;
            end else if (count_r >= DEPTH_C) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we       = 1'b1;
              mem_wd       = {sto_r, rel_r};
              count_nxt    = count_r + CW'(1);
              ro_nxt       = rel_r;
              so_nxt       = sto_r;
              highest_nxt  = end_r;
              last_rel_nxt = rel_r;
              last_sto_nxt = sto_r;
            end
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end

      S_SEARCH: begin
        // rd_data_r holds the entry at mid_r.
        lo_nxt = lo_n;
        hi_nxt = hi_n;
        if (lo_n < hi_n) begin
          mid_nxt = mid_n;
          rd_en   = 1'b1;
          rd_addr = mid_n[AW-1:0];
        end else if (lo_n == '0) begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_DONE;
        end else begin
          mid_nxt   = lo_n - CW'(1);
          rd_en     = 1'b1;
          rd_addr   = mid_nxt[AW-1:0];
          state_nxt = S_FETCH;
        end
      end

      S_FETCH: begin
        diff_nxt  = key - ent_key;
        base_nxt  = ent_other;
        state_nxt = S_ADD;
      end

      S_ADD: begin
        res_page_nxt   = base_r + diff_r;
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_page_nxt   = res_page_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Only one request is in flight, so a write and a later read of the same
  // entry never overlap.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      so_r        <= '0;
      ro_r        <= '0;
      highest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      so_r        <= so_nxt;
      ro_r        <= ro_nxt;
      highest_r   <= highest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    sto_r         <= sto_nxt;
    rel_r         <= rel_nxt;
    cnt_r         <= cnt_nxt;
    first_r       <= first_nxt;
    last_rel_r    <= last_rel_nxt;
    last_sto_r    <= last_sto_nxt;
    sd_r          <= sd_nxt;
    sto_lt_r      <= sto_lt_nxt;
    rd_r          <= rd_nxt;
    rel_lt_r      <= rel_lt_nxt;
    end_r         <= end_nxt;
    end_ovf_r     <= end_ovf_nxt;
    rel_le_last_r <= rel_le_last_nxt;
    sto_le_last_r <= sto_le_last_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    mid_r         <= mid_nxt;
    diff_r        <= diff_nxt;
    base_r        <= base_nxt;
    res_page_r    <= res_page_nxt;
    res_status_r  <= res_status_nxt;
    out_page_r    <= out_page_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_page_r;
  assign out_tuser  = out_status_r;

endmodule

// File: rtl/rpem_checker.sv
// ----------------------------------------------------------------------------
// Relative page extent map port checker
// Watches the stream ports of the block and flags illegal behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "relative_page_extent_map_assert.svh"

module rpem_checker import rpem_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // A stalled result keeps its contents.
  `RPEM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // Every failed request reports a zero page.
  `RPEM_ASSERT_SAME(a_err_zero_page, out_tvalid && out_tuser != ST_OK, out_tdata == '0, "error result with nonzero page")

  // One request at a time: the input closes right after an acceptance.
  `RPEM_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "input ready right after acceptance")

  // Reset leaves no result pending and the input open.
  `RPEM_ASSERT_RST(a_reset_state, !rst_n, !out_tvalid && in_tready, "bad state after reset")

endmodule

bind relative_page_extent_map rpem_checker u_rpem_checker (.*);
